@@ hw/rtl/radix_suffix_number_scanner_assert.svh @@
// Assertion macros for the checker module of the radix suffix number scanner.
`ifndef RADIX_SUFFIX_NUMBER_SCANNER_ASSERT_SVH
`define RADIX_SUFFIX_NUMBER_SCANNER_ASSERT_SVH

// Overlapping implication: the consequent must hold in the same cycle.
`define RSSN_ASSERT_SAME(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication: the consequent must hold in the next cycle.
`define RSSN_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rssn_pkg.sv @@
// Package with the codes, character constants and field widths of the radix suffix scanner.
`default_nettype none

package rssn_pkg;

    // Result field widths.
    localparam int NUMBER_W = 16;
    localparam int COUNT_W  = 8;
    localparam int RADIX_W  = 2;
    localparam int CHAR_W   = 7;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // Radix codes, also the index of each invalid-digit counter.
    typedef enum logic [RADIX_W-1:0] {
        RADIX_BIN = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_DEC = 2'd2,
        RADIX_HEX = 2'd3
    } radix_t;

    // Character constants.
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_LC_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC_Z = 7'h7A;
    localparam logic [CHAR_W-1:0] CHAR_H    = 7'h48;
    localparam logic [CHAR_W-1:0] CHAR_D    = 7'h44;
    localparam logic [CHAR_W-1:0] CHAR_Q    = 7'h51;
    localparam logic [CHAR_W-1:0] CHAR_O    = 7'h4F;
    localparam logic [CHAR_W-1:0] CHAR_B    = 7'h42;
    localparam logic [CHAR_W-1:0] CHAR_LC_H = 7'h68;

    // Case folding distance and the gap between '9' and 'A'.
    localparam logic [CHAR_W-1:0] CASE_GAP   = 7'd32;
    localparam logic [7:0]        LETTER_GAP = 8'd7;

    // Bases compared against the digit value.
    localparam logic [7:0] BASE_BIN = 8'd2;
    localparam logic [7:0] BASE_OCT = 8'd8;
    localparam logic [7:0] BASE_DEC = 8'd10;
    localparam logic [7:0] BASE_HEX = 8'd16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

`default_nettype wire

@@ hw/rtl/radix_suffix_number_scanner.sv @@
// Top level of the radix suffix number scanner: digit accumulators and result register.
//
//  Channel  | Direction | Payload
//  ---------+-----------+------------------------------------------------------------
//  s_       | in        | tdata[6:0] token_char, tlast last_char
//  m_       | out       | tdata[15:0] number_value, [23:16] bad_digit_count; tuser radix_code
//
// One character is taken every cycle; each transfer is folded into the four accumulators
// by one shift-and-add stage, and a final character loads the result register at the edge
// of its transfer, so the result is offered in the next cycle. The result register is the
// only buffer: s_tready drops only while a result waits and m_tready is low. aresetn is
// synchronous and clears the accumulators, the counters and the result valid flag.
`default_nettype none

module radix_suffix_number_scanner #(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input channel.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [rssn_pkg::S_TDATA_W-1:0]  s_tdata,  // [6:0] token_char, [7] zero
    input  wire logic                            s_tlast,
    // Result channel.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [rssn_pkg::M_TDATA_W-1:0]       m_tdata,  // [15:0] number_value,
                                                           // [23:16] bad_digit_count
    output logic [rssn_pkg::RADIX_W-1:0]         m_tuser   // [1:0] radix_code
);

    localparam int EXT_W = (VALUE_WIDTH > rssn_pkg::NUMBER_W) ? VALUE_WIDTH
                                                              : rssn_pkg::NUMBER_W;

    logic [VALUE_WIDTH-1:0] acc_bin_reg, acc_oct_reg, acc_dec_reg, acc_hex_reg;
    logic [VALUE_WIDTH-1:0] acc_bin_next, acc_oct_next, acc_dec_next, acc_hex_next;
    logic [3:0][rssn_pkg::COUNT_W-1:0] bad_reg, bad_next;

    logic                             out_valid_reg;
    logic [rssn_pkg::NUMBER_W-1:0]    out_value_reg, out_value_next;
    logic [rssn_pkg::COUNT_W-1:0]     out_count_reg, out_count_next;
    rssn_pkg::radix_t                 out_radix_reg, out_radix_next;

    logic                             in_xfer;
    logic [rssn_pkg::CHAR_W-1:0]      char_raw, char_up;
    logic                             digit_neg;
    logic [7:0]                       digit_u;
    logic signed [7:0]                digit_s;
    logic [VALUE_WIDTH-1:0]           digit_ext;
    logic [3:0]                       digit_bad;
    logic [VALUE_WIDTH-1:0]           step_bin, step_oct, step_dec, step_hex;
    logic [3:0][rssn_pkg::COUNT_W-1:0] step_bad;
    logic [VALUE_WIDTH-1:0]           sel_value;
    logic [EXT_W-1:0]                 sel_value_ext;

    // The result register takes a new result whenever it is empty or being drained.
    assign s_tready = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    // Fold to upper case and form the signed digit value.
    always_comb begin
        char_raw = s_tdata[rssn_pkg::CHAR_W-1:0];
        if (char_raw inside {[rssn_pkg::CHAR_LC_A:rssn_pkg::CHAR_LC_Z]}) begin
            char_up = char_raw - rssn_pkg::CASE_GAP;
        end else begin
            char_up = char_raw;
        end
        digit_neg = (char_up < rssn_pkg::CHAR_ZERO);
        digit_u   = {1'b0, char_up} - {1'b0, rssn_pkg::CHAR_ZERO};
        if (!digit_neg && (char_up > rssn_pkg::CHAR_NINE)) begin
            digit_u = digit_u - rssn_pkg::LETTER_GAP;
        end
        digit_s   = $signed(digit_u);
        digit_ext = VALUE_WIDTH'(digit_s);
    end

    // A digit is invalid for a radix when it is negative or not below the base.
    always_comb begin
        digit_bad[rssn_pkg::RADIX_BIN] = digit_neg || (digit_u >= rssn_pkg::BASE_BIN);
        digit_bad[rssn_pkg::RADIX_OCT] = digit_neg || (digit_u >= rssn_pkg::BASE_OCT);
        digit_bad[rssn_pkg::RADIX_DEC] = digit_neg || (digit_u >= rssn_pkg::BASE_DEC);
        digit_bad[rssn_pkg::RADIX_HEX] = digit_neg || (digit_u >= rssn_pkg::BASE_HEX);
    end

    // Accumulators after taking the current character as a digit; constant
    // multiplies are shifts, times ten is eight plus two.
    always_comb begin
        step_bin = (acc_bin_reg << 1) + digit_ext;
        step_oct = (acc_oct_reg << 3) + digit_ext;
        step_dec = (acc_dec_reg << 3) + (acc_dec_reg << 1) + digit_ext;
        step_hex = (acc_hex_reg << 4) + digit_ext;
        for (int r = 0; r < 4; r++) begin
            if (digit_bad[r] && (bad_reg[r] != rssn_pkg::COUNT_MAX)) begin
                step_bad[r] = bad_reg[r] + rssn_pkg::COUNT_W'(1);
            end else begin
                step_bad[r] = bad_reg[r];
            end
        end
    end

    // A final H, D, Q, O or B selects the radix and is not converted.
    always_comb begin
        case (char_up)
            rssn_pkg::CHAR_H: begin
                out_radix_next = rssn_pkg::RADIX_HEX;
                sel_value      = acc_hex_reg;
                out_count_next = bad_reg[rssn_pkg::RADIX_HEX];
            end
            rssn_pkg::CHAR_D: begin
                out_radix_next = rssn_pkg::RADIX_DEC;
                sel_value      = acc_dec_reg;
                out_count_next = bad_reg[rssn_pkg::RADIX_DEC];
            end
            rssn_pkg::CHAR_Q, rssn_pkg::CHAR_O: begin
                out_radix_next = rssn_pkg::RADIX_OCT;
                sel_value      = acc_oct_reg;
                out_count_next = bad_reg[rssn_pkg::RADIX_OCT];
            end
            rssn_pkg::CHAR_B: begin
                out_radix_next = rssn_pkg::RADIX_BIN;
                sel_value      = acc_bin_reg;
                out_count_next = bad_reg[rssn_pkg::RADIX_BIN];
            end
            default: begin
                out_radix_next = rssn_pkg::RADIX_DEC;
                sel_value      = step_dec;
                out_count_next = step_bad[rssn_pkg::RADIX_DEC];
            end
        endcase
        sel_value_ext  = EXT_W'(sel_value);
        out_value_next = sel_value_ext[rssn_pkg::NUMBER_W-1:0];
    end

    // Next token state: a final character clears everything, any other one folds in.
    always_comb begin
        acc_bin_next = acc_bin_reg;
        acc_oct_next = acc_oct_reg;
        acc_dec_next = acc_dec_reg;
        acc_hex_next = acc_hex_reg;
        bad_next     = bad_reg;
        if (in_xfer) begin
            if (s_tlast) begin
                acc_bin_next = '0;
                acc_oct_next = '0;
                acc_dec_next = '0;
                acc_hex_next = '0;
                bad_next     = '0;
            end else begin
                acc_bin_next = step_bin;
                acc_oct_next = step_oct;
                acc_dec_next = step_dec;
                acc_hex_next = step_hex;
                bad_next     = step_bad;
            end
        end
    end

    // Token state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_bin_reg <= '0;
            acc_oct_reg <= '0;
            acc_dec_reg <= '0;
            acc_hex_reg <= '0;
            bad_reg     <= '0;
        end else begin
            acc_bin_reg <= acc_bin_next;
            acc_oct_reg <= acc_oct_next;
            acc_dec_reg <= acc_dec_next;
            acc_hex_reg <= acc_hex_next;
            bad_reg     <= bad_next;
        end
    end

    // Result register: loaded by a final character, emptied by an output transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_xfer && s_tlast) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && s_tlast) begin
            out_value_reg <= out_value_next;
            out_count_reg <= out_count_next;
            out_radix_reg <= out_radix_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_value_reg};
    assign m_tuser  = out_radix_reg;

endmodule

`default_nettype wire

@@ hw/rtl/rssn_checker.sv @@
// Port-level checker for the radix suffix number scanner, bound to the top level.
`default_nettype none

`include "radix_suffix_number_scanner_assert.svh"

module rssn_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [rssn_pkg::S_TDATA_W-1:0]  s_tdata,
    input wire logic                            s_tlast,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [rssn_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic [rssn_pkg::RADIX_W-1:0]    m_tuser
);

    // A result that is not taken holds its value.
    `RSSN_ASSERT_NEXT(a_result_holds, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Reset empties the result register.
    `RSSN_ASSERT_NEXT(a_reset_empty, aclk, 1'b0, !aresetn, !m_tvalid, "result valid after reset")

    // A new result only appears after a final-character transfer.
    `RSSN_ASSERT_SAME(a_result_cause, aclk, !aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready && s_tlast), "result without a final transfer")

    // The input side is never held off while no result is waiting.
    `RSSN_ASSERT_SAME(a_ready_when_empty, aclk, !aresetn, !m_tvalid, s_tready, "input stalled with empty output")

    // A final H suffix reports a hexadecimal result in the next cycle.
    `RSSN_ASSERT_NEXT(a_hex_suffix, aclk, !aresetn, s_tvalid && s_tready && s_tlast && ((s_tdata[6:0] == rssn_pkg::CHAR_H) || (s_tdata[6:0] == rssn_pkg::CHAR_LC_H)), m_tvalid && (m_tuser == rssn_pkg::RADIX_HEX), "H suffix did not give hex result")

endmodule

bind radix_suffix_number_scanner rssn_checker u_rssn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the radix suffix number scanner.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAR_W    = rssn_pkg::CHAR_W;
    localparam int NUMBER_W  = rssn_pkg::NUMBER_W;
    localparam int COUNT_W   = rssn_pkg::COUNT_W;
    localparam int RADIX_W   = rssn_pkg::RADIX_W;
    localparam int S_TDATA_W = rssn_pkg::S_TDATA_W;
    localparam int M_TDATA_W = rssn_pkg::M_TDATA_W;

    localparam int ITEM_TARGET  = 750;
    localparam int LONG_TOKEN   = 262;
    localparam int LONG_HOLD    = 150;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [CHAR_W-1:0] LETTER_A = 7'h41;
    localparam logic [CHAR_W-1:0] QUESTION = 7'h3F;

    // One character transfer waiting to be offered.
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        int unsigned       gap;
    } token_char_t;

    // One reported literal.
    typedef struct {
        logic [NUMBER_W-1:0] value;
        rssn_pkg::radix_t    radix;
        logic [COUNT_W-1:0]  bad_count;
    } literal_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [RADIX_W-1:0]   m_tuser;

    radix_suffix_number_scanner dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock: 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    token_char_t         char_queue [$];
    literal_t            expected_literals [$];
    logic [NUMBER_W-1:0] digit_acc [4];
    logic [COUNT_W-1:0]  bad_digits [4];
    int                  error_count = 0;
    bit                  send_calm = 1'b0;
    bit                  recv_calm = 1'b0;
    int                  items_queued = 0;

    function automatic int radix_base(input int r);
        case (r)
            rssn_pkg::RADIX_BIN: return int'(rssn_pkg::BASE_BIN);
            rssn_pkg::RADIX_OCT: return int'(rssn_pkg::BASE_OCT);
            rssn_pkg::RADIX_DEC: return int'(rssn_pkg::BASE_DEC);
            default:             return int'(rssn_pkg::BASE_HEX);
        endcase
    endfunction

    function automatic void clear_literal();
        for (int r = 0; r < 4; r++) begin
            digit_acc[r]  = '0;
            bad_digits[r] = '0;
        end
    endfunction

    // Fold one digit into all four accumulators; digits outside a radix still add.
    function automatic void take_digit(input logic [CHAR_W-1:0] ch);
        int d;
        int base;
        d = int'(ch) - int'(rssn_pkg::CHAR_ZERO);
        if (d > 9) begin
            d = d - int'(rssn_pkg::LETTER_GAP);
        end
        for (int r = 0; r < 4; r++) begin
            base = radix_base(r);
            digit_acc[r] = NUMBER_W'(digit_acc[r] * base + d);
            if ((d < 0 || d >= base) && bad_digits[r] != rssn_pkg::COUNT_MAX) begin
                bad_digits[r] = bad_digits[r] + 1'b1;
            end
        end
    endfunction

    // Scanner behaviour for one accepted character; a final one yields a literal.
    function automatic void scan_char(input logic [CHAR_W-1:0] raw, input logic is_last);
        logic [CHAR_W-1:0] ch;
        bit                is_suffix;
        literal_t          lit;
        ch = raw;
        if (ch >= rssn_pkg::CHAR_LC_A && ch <= rssn_pkg::CHAR_LC_Z) begin
            ch = ch - rssn_pkg::CASE_GAP;
        end
        is_suffix = is_last && (ch == rssn_pkg::CHAR_H || ch == rssn_pkg::CHAR_D ||
                                ch == rssn_pkg::CHAR_Q || ch == rssn_pkg::CHAR_O ||
                                ch == rssn_pkg::CHAR_B);
        if (!is_suffix) begin
            take_digit(ch);
        end
        if (is_last) begin
            if (!is_suffix) begin
                lit.radix = rssn_pkg::RADIX_DEC;
            end else begin
                case (ch)
                    rssn_pkg::CHAR_H: lit.radix = rssn_pkg::RADIX_HEX;
                    rssn_pkg::CHAR_D: lit.radix = rssn_pkg::RADIX_DEC;
                    rssn_pkg::CHAR_Q, rssn_pkg::CHAR_O: lit.radix = rssn_pkg::RADIX_OCT;
                    default:          lit.radix = rssn_pkg::RADIX_BIN;
                endcase
            end
            lit.value     = digit_acc[lit.radix];
            lit.bad_count = bad_digits[lit.radix];
            expected_literals.push_back(lit);
            clear_literal();
        end
    endfunction

    // Queue one character with its lead-in gap; calm stretches offer back to back.
    function automatic void push_char(input logic [CHAR_W-1:0] ch, input logic is_last);
        token_char_t item;
        if ($urandom_range(0, 29) == 0) begin
            send_calm = !send_calm;
        end
        item.ch   = ch;
        item.last = is_last;
        item.gap  = send_calm ? 0 : $urandom_range(0, 19);
        char_queue.push_back(item);
        items_queued++;
    endfunction

    function automatic void push_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            push_char(CHAR_W'(text[i]), i == text.len() - 1);
        end
    endfunction

    function automatic logic [CHAR_W-1:0] random_case(input logic [CHAR_W-1:0] ch);
        return ($urandom_range(0, 1) == 1) ? ch + rssn_pkg::CASE_GAP : ch;
    endfunction

    // Mostly plausible digits, with a share of arbitrary characters.
    function automatic logic [CHAR_W-1:0] random_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return rssn_pkg::CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
            4, 5:       return random_case(LETTER_A + CHAR_W'($urandom_range(0, 5)));
            6:          return random_case(LETTER_A + CHAR_W'($urandom_range(0, 25)));
            7:          return QUESTION + CHAR_W'($urandom_range(0, 1));
            default:    return CHAR_W'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] random_final();
        if ($urandom_range(0, 1) == 1) begin
            return random_char();
        end
        case ($urandom_range(0, 4))
            0:       return random_case(rssn_pkg::CHAR_H);
            1:       return random_case(rssn_pkg::CHAR_D);
            2:       return random_case(rssn_pkg::CHAR_Q);
            3:       return random_case(rssn_pkg::CHAR_O);
            default: return random_case(rssn_pkg::CHAR_B);
        endcase
    endfunction

    // Sender: offers queued characters, each after its own gap.
    token_char_t next_item;
    bit          staged = 1'b0;
    int unsigned send_wait = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tlast  <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                scan_char(s_tdata[CHAR_W-1:0], s_tlast);
            end
            if (!s_tvalid || s_tready) begin
                if (!staged && char_queue.size() > 0) begin
                    next_item = char_queue.pop_front();
                    staged    = 1'b1;
                    send_wait = next_item.gap;
                end
                if (staged && send_wait == 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'(next_item.ch);
                    s_tlast  <= next_item.last;
                    staged   = 1'b0;
                end else begin
                    s_tvalid <= 1'b0;
                    if (staged) begin
                        send_wait--;
                    end
                end
            end
        end
    end

    function automatic int unsigned draw_stall();
        if ($urandom_range(0, 19) == 0) begin
            recv_calm = !recv_calm;
        end
        return recv_calm ? 0 : $urandom_range(0, 19);
    endfunction

    // Receiver: checks each literal and stalls at random, twice for a long stretch.
    int unsigned stall_left   = 0;
    int unsigned hold_left    = 0;
    int          results_seen = 0;
    literal_t    want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_literals.size() == 0) begin
                    $error("literal transfer with none expected: value %0h radix %0d count %0d",
                           m_tdata[15:0], m_tuser, m_tdata[23:16]);
                    error_count++;
                end else begin
                    want = expected_literals.pop_front();
                    if (m_tdata[15:0] !== want.value) begin
                        $error("number_value: expected %0h, got %0h", want.value,
                               m_tdata[15:0]);
                        error_count++;
                    end
                    if (m_tuser !== want.radix) begin
                        $error("radix_code: expected %0d, got %0d", want.radix, m_tuser);
                        error_count++;
                    end
                    if (m_tdata[23:16] !== want.bad_count) begin
                        $error("bad_digit_count: expected %0d, got %0d", want.bad_count,
                               m_tdata[23:16]);
                        error_count++;
                    end
                end
                results_seen++;
                stall_left = draw_stall();
                if (results_seen == 30 || results_seen == 60) begin
                    hold_left = LONG_HOLD;
                end
            end else if (m_tvalid && stall_left > 0) begin
                stall_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (stall_left == 0);
            end
        end
    end

    // Watchdog: too long without any transfer ends the run.
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int token_count;
        int len;
        clear_literal();

        // Directed: suffix-only token, character extremes, every suffix, H and B in both cases,
        // invalid digits, characters below '0' and a token ending in a plain digit.
        push_text("h");
        push_char(7'h00, 1'b0);
        push_char(7'h7F, 1'b1);
        push_text("zD");
        push_text("?@B");
        push_text("1011b");
        push_text("17Q");
        push_text("9o");
        push_text("FFFFH");
        push_text("!5");

        // Random tokens; one long run of letters drives the counters to saturation.
        token_count = 0;
        while (items_queued < ITEM_TARGET) begin
            if (token_count == 8) begin
                len = LONG_TOKEN;
                for (int i = 0; i < len - 1; i++) begin
                    push_char(random_case(LETTER_A + CHAR_W'($urandom_range(6, 25))), 1'b0);
                end
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                  : $urandom_range(1, 8);
                for (int i = 0; i < len - 1; i++) begin
                    push_char(random_char(), 1'b0);
                end
            end
            push_char(random_final(), 1'b1);
            token_count++;
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (char_queue.size() > 0 || staged || s_tvalid);
        while (expected_literals.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
